@@ design/bcc_pkg.sv @@
// Package for the button click classifier.
// Holds phase, event and register index codes and the configuration struct.
// No dependencies.
package bcc_pkg;

  localparam int unsigned TickWidth = 16;
  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  localparam logic                 IdleLevelReset   = 1'b0;
  localparam logic [TickWidth-1:0] DoubleTicksReset = 16'd20;
  localparam logic [TickWidth-1:0] LongTicksReset   = 16'd100;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESS1   = 2'd1,
    PH_RELEASE1 = 2'd2,
    PH_PRESS2   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    REG_IDLE_LEVEL   = 2'd0,
    REG_DOUBLE_TICKS = 2'd1,
    REG_LONG_TICKS   = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic                 idle_level;
    logic [TickWidth-1:0] double_press_ticks;
    logic [TickWidth-1:0] long_press_ticks;
  } cfg_t;

endpackage

@@ design/bcc_in_if.sv @@
// Input channel of the button click classifier: one scan tick per transfer.
// No dependencies.
interface bcc_in_if;
  logic valid;
  logic ready;
  logic sample_level;

  modport source (output valid, output sample_level, input ready);
  modport sink (input valid, input sample_level, output ready);
endinterface

@@ design/bcc_out_if.sv @@
// Result channel of the button click classifier: one event code per transfer.
// No dependencies.
interface bcc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_code;

  modport source (output valid, output event_code, input ready);
  modport sink (input valid, input event_code, output ready);
endinterface

@@ design/bcc_fsm.sv @@
// Click classification state machine: phase, tick counter and previous level.
// Depends on bcc_pkg.
module bcc_fsm import bcc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   step,
  input  logic   sample_level,
  input  cfg_t   cfg,
  output event_t evt
);

  phase_t               phase_r, phase_nxt;
  logic [TickWidth-1:0] tick_r, tick_nxt;
  logic                 prev_r;
  logic [TickWidth-1:0] tick_inc;
  logic                 same_level;
  logic                 long_hit;
  logic                 double_hit;

  assign tick_inc   = tick_r + TickWidth'(1);
  assign same_level = (sample_level == prev_r);
  assign long_hit   = (tick_inc >= cfg.long_press_ticks);
  assign double_hit = (tick_inc >= cfg.double_press_ticks);

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (sample_level != cfg.idle_level && prev_r == cfg.idle_level) begin
          phase_nxt = PH_PRESS1;
        end
      end
      PH_PRESS1: begin
        if (same_level) begin
          tick_nxt = long_hit ? '0 : tick_inc;
          if (long_hit) begin
            phase_nxt = PH_IDLE;
          end
        end else begin
          tick_nxt  = '0;
          phase_nxt = PH_RELEASE1;
        end
      end
      PH_RELEASE1: begin
        if (same_level) begin
          tick_nxt = double_hit ? '0 : tick_inc;
          if (double_hit) begin
            phase_nxt = PH_IDLE;
          end
        end else begin
          tick_nxt  = '0;
          phase_nxt = PH_PRESS2;
        end
      end
      PH_PRESS2: begin
        if (!same_level) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    evt = EV_NONE;
    unique case (phase_r)
      PH_IDLE:     evt = EV_NONE;
      PH_PRESS1:   evt = (same_level && long_hit) ? EV_LONG : EV_NONE;
      PH_RELEASE1: evt = (same_level && double_hit) ? EV_SINGLE : EV_NONE;
      PH_PRESS2:   evt = same_level ? EV_NONE : EV_DOUBLE;
      default:     evt = EV_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      prev_r  <= IdleLevelReset;
    end else if (step) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      prev_r  <= sample_level;
    end
  end

endmodule

@@ design/button_click_classifier.sv @@
// Button click classifier top level: channels, register file and result register.
// Depends on bcc_pkg, bcc_in_if, bcc_out_if and bcc_fsm.
//
// Each input transfer is one scan tick carrying the sampled button level, and
// each produces exactly one event code (none, single, double or long press).
// A tick is classified in the cycle it is taken and its code appears in the
// result register in the next cycle; a new tick is taken every cycle while the
// result register is empty or being drained, so throughput is one tick per
// cycle. Registers: idle level at 0x0, release ticks for a single click at
// 0x4, held ticks for a long press at 0x8; write them only while no tick is
// in flight.
module button_click_classifier import bcc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  bcc_in_if.sink               in_chan,
  bcc_out_if.source            out_chan,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  cfg_t     cfg_r;
  reg_idx_t reg_idx;
  logic     cfg_wr;
  logic     in_acc;
  logic     out_valid_r;
  event_t   event_r;
  event_t   evt;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_level         <= IdleLevelReset;
      cfg_r.double_press_ticks <= DoubleTicksReset;
      cfg_r.long_press_ticks   <= LongTicksReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_IDLE_LEVEL:   cfg_r.idle_level         <= pwdata[0];
        REG_DOUBLE_TICKS: cfg_r.double_press_ticks <= pwdata[TickWidth-1:0];
        REG_LONG_TICKS:   cfg_r.long_press_ticks   <= pwdata[TickWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IDLE_LEVEL:   prdata = {{(DataWidth-1){1'b0}}, cfg_r.idle_level};
      REG_DOUBLE_TICKS: prdata = {{(DataWidth-TickWidth){1'b0}}, cfg_r.double_press_ticks};
      REG_LONG_TICKS:   prdata = {{(DataWidth-TickWidth){1'b0}}, cfg_r.long_press_ticks};
      default:          prdata = '0;
    endcase
  end

  assign in_chan.ready = rst_n && (!out_valid_r || out_chan.ready);
  assign in_acc        = in_chan.valid && in_chan.ready;

  bcc_fsm u_fsm (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_acc),
    .sample_level (in_chan.sample_level),
    .cfg          (cfg_r),
    .evt          (evt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      event_r <= evt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.event_code = event_r;

endmodule

@@ design/bcc_checker.sv @@
// Port-level checks for the button click classifier, bound to the top level.
// Depends on bcc_pkg and button_click_classifier.
module bcc_checker import bcc_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [1:0]           event_code,
  input logic                 psel,
  input logic [AddrWidth-1:0] paddr,
  input logic [DataWidth-1:0] prdata
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_code))
    else $error("stalled result changed or dropped");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled while result stage free");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("transfer produced no result");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without input transfer");

  a_idle_read: assert property (@(posedge clk) disable iff (!rst_n)
    psel && paddr[3:2] == REG_IDLE_LEVEL |-> prdata[DataWidth-1:1] == '0)
    else $error("idle level readback has stray bits");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .event_code (out_chan.event_code),
  .psel       (psel),
  .paddr      (paddr),
  .prdata     (prdata)
);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for button_click_classifier: scan ticks in, event codes out,
// scoreboard fed by a tick-level predictor. Depends on bcc_pkg, bcc_in_if, bcc_out_if.
module testbench;
  import bcc_pkg::*;

  localparam int CycleLimit = 400_000;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic pready;

  bcc_in_if in_ch ();
  bcc_out_if out_ch ();

  button_click_classifier uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_ch),
    .out_chan(out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cfg_t shadow_cfg;
  phase_t btn_phase;
  logic [TickWidth-1:0] hold_ticks;
  logic last_level_seen;

  event_t pending_events[$];
  int failures;
  int cycle_count;
  int in_max_gap;
  int out_max_gap;
  logic stim_level;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic event_t classify_tick(input logic lvl);
    event_t ev;
    ev = EV_NONE;
    case (btn_phase)
      PH_IDLE: begin
        if (lvl != shadow_cfg.idle_level && last_level_seen == shadow_cfg.idle_level) begin
          btn_phase = PH_PRESS1;
        end
      end
      PH_PRESS1: begin
        if (lvl == last_level_seen) begin
          hold_ticks = hold_ticks + 1'b1;
          if (hold_ticks >= shadow_cfg.long_press_ticks) begin
            hold_ticks = '0;
            btn_phase = PH_IDLE;
            ev = EV_LONG;
          end
        end else begin
          hold_ticks = '0;
          btn_phase = PH_RELEASE1;
        end
      end
      PH_RELEASE1: begin
        if (lvl == last_level_seen) begin
          hold_ticks = hold_ticks + 1'b1;
          if (hold_ticks >= shadow_cfg.double_press_ticks) begin
            hold_ticks = '0;
            btn_phase = PH_IDLE;
            ev = EV_SINGLE;
          end
        end else begin
          hold_ticks = '0;
          btn_phase = PH_PRESS2;
        end
      end
      default: begin
        if (lvl != last_level_seen) begin
          btn_phase = PH_IDLE;
          ev = EV_DOUBLE;
        end
      end
    endcase
    last_level_seen = lvl;
    return ev;
  endfunction

  function automatic logic [DataWidth-1:0] reg_value(input reg_idx_t idx);
    case (idx)
      REG_IDLE_LEVEL:   return DataWidth'(shadow_cfg.idle_level);
      REG_DOUBLE_TICKS: return DataWidth'(shadow_cfg.double_press_ticks);
      REG_LONG_TICKS:   return DataWidth'(shadow_cfg.long_press_ticks);
      default:          return '0;
    endcase
  endfunction

  always @(posedge clk) begin
    event_t exp_ev;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        pending_events.push_back(classify_tick(in_ch.sample_level));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_events.size() == 0) begin
          $error("event_code expected none pending, actual %0d", out_ch.event_code);
          failures++;
        end else begin
          exp_ev = pending_events.pop_front();
          if (out_ch.event_code !== exp_ev) begin
            $error("event_code expected %0d, actual %0d", exp_ev, out_ch.event_code);
            failures++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      gap = $urandom_range(0, out_max_gap);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task automatic send_tick(input logic lvl);
    int gap;
    gap = $urandom_range(0, in_max_gap);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_level <= lvl;
    stim_level = lvl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_events();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_read_check(input reg_idx_t idx);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= AddrWidth'({idx, 2'b00});
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== reg_value(idx)) begin
      $error("%s expected %0d, actual %0d", idx.name(), reg_value(idx), prdata);
      failures++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [DataWidth-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrWidth'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_IDLE_LEVEL:   shadow_cfg.idle_level = value[0];
      REG_DOUBLE_TICKS: shadow_cfg.double_press_ticks = value[TickWidth-1:0];
      REG_LONG_TICKS:   shadow_cfg.long_press_ticks = value[TickWidth-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx != REG_UNUSED) cfg_read_check(idx);
  endtask

  task automatic apply_settings(input logic idle, input int dbl, input int lng);
    drain_events();
    cfg_write(REG_IDLE_LEVEL, DataWidth'(idle));
    cfg_write(REG_DOUBLE_TICKS, DataWidth'(dbl));
    cfg_write(REG_LONG_TICKS, DataWidth'(lng));
  endtask

  task automatic send_runs(input int n_items, input int max_run);
    int sent;
    int run;
    logic lvl;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        lvl = $urandom_range(0, 1);
        run = 1;
      end else begin
        lvl = ($urandom_range(0, 4) == 0) ? stim_level : ~stim_level;
        run = $urandom_range(1, max_run);
      end
      repeat (run) send_tick(lvl);
      sent += run;
    end
  endtask

  task automatic send_levels(input logic [31:0] levels, input int count);
    for (int i = count - 1; i >= 0; i--) send_tick(levels[i]);
  endtask

  task automatic test_register_reset();
    cfg_read_check(REG_IDLE_LEVEL);
    cfg_read_check(REG_DOUBLE_TICKS);
    cfg_read_check(REG_LONG_TICKS);
    in_max_gap = 10;
    out_max_gap = 10;
    send_runs(250, 110);
  endtask

  task automatic test_directed_sequences();
    apply_settings(1'b0, 2, 3);
    cfg_write(REG_UNUSED, '1);
    in_max_gap = 0;
    out_max_gap = 0;
    // long press, release while pressed-level lingers, double, single
    send_levels(32'b0_1111_0_1_0_1_1_0_1_0_0_0, 15);
  endtask

  task automatic test_zero_thresholds();
    apply_settings(1'b1, 0, 0);
    in_max_gap = 3;
    out_max_gap = 3;
    send_levels(32'b1_0_0_1_0_0_1_1_0_1, 10);
    apply_settings(1'b0, 1, 1);
    send_runs(40, 4);
  endtask

  task automatic test_random_settings();
    int dbl;
    int lng;
    for (int p = 0; p < 8; p++) begin
      dbl = $urandom_range(0, 12);
      lng = $urandom_range(0, 16);
      apply_settings($urandom_range(0, 1), dbl, lng);
      in_max_gap = ($urandom_range(0, 2) == 0) ? 0 : 10;
      out_max_gap = ($urandom_range(0, 2) == 0) ? 0 : 10;
      send_runs(150, ((dbl > lng) ? dbl : lng) + 3);
    end
  endtask

  task automatic test_counter_extremes();
    apply_settings(1'b0, 150, 200);
    in_max_gap = 0;
    out_max_gap = 0;
    send_tick(1'b0);
    repeat (201) send_tick(1'b1);
    send_levels(32'b0_1_0, 3);
    repeat (150) send_tick(1'b0);
    in_max_gap = 10;
    out_max_gap = 10;
    send_runs(60, 8);
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.sample_level = 1'b0;
    failures = 0;
    cycle_count = 0;
    in_max_gap = 0;
    out_max_gap = 0;
    stim_level = 1'b0;
    shadow_cfg = '{idle_level: IdleLevelReset, double_press_ticks: DoubleTicksReset,
                   long_press_ticks: LongTicksReset};
    btn_phase = PH_IDLE;
    hold_ticks = '0;
    last_level_seen = IdleLevelReset;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_reset();
    test_directed_sequences();
    test_zero_thresholds();
    test_random_settings();
    test_counter_extremes();

    drain_events();
    repeat (4) @(posedge clk);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
